### hw/rtl/smm_pkg.sv
`timescale 1ns / 1ps
package smm_pkg;
  localparam int MAX_ROWS_DEF  = 64;
  localparam int MAX_INNER_DEF = 64;
  localparam int A_ENTRIES_DEF = 1024;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 63;

  typedef enum logic [1:0] {
    REQ_A_PTR   = 2'd0,
    REQ_A_ENTRY = 2'd1,
    REQ_B_ENTRY = 2'd2,
    REQ_B_END   = 2'd3
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_ROWS    = 2'd0,
    CFG_A_COLS    = 2'd1,
    CFG_THRESHOLD = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [6:0]         a_col;
    logic [10:0]        a_ptr;
    logic [9:0]         a_pos;
    logic [5:0]         a_row;
    logic signed [31:0] a_value;
    logic [5:0]         b_row;
    logic signed [31:0] b_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         out_row;
    logic signed [63:0] out_value;
    logic               col_last;
    logic               col_empty;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PTR0,
    ST_PTR1,
    ST_PTR2,
    ST_WALK_RD,
    ST_WALK_WAIT,
    ST_WALK_MUL,
    ST_WALK_ACC,
    ST_SCAN,
    ST_SCAN_ACC,
    ST_SCAN_EMIT,
    ST_EMPTY
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;      // latch accepted item
    logic write_ptr;
    logic write_entry;
    logic rd_end;       // read end pointer, latch start
    logic load_end;     // latch end
    logic rd_entry;     // advance walk position
    logic mul;          // register product, read row accumulator
    logic acc;          // accumulate into row
    logic scan_pick;    // pick lowest touched row, read its accumulator
    logic scan_check;   // compare and clear row
    logic hold_row;     // park kept row until the next one or column end
    logic emit_row;     // send parked row, not last
    logic emit_last;    // send parked row as last, or the empty marker
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic b_valid;      // b entry in range
    logic walk_done;
    logic row_ok;
    logic any_touched;
    logic keep;
    logic pend_valid;   // a kept row is parked
  } stat_t;
endpackage

### hw/rtl/smm_ram.sv
`timescale 1ns / 1ps
module smm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/smm_ctrl.sv
`timescale 1ns / 1ps
module smm_ctrl
  import smm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  req_type_t in_type,
  input  logic      out_stall,
  input  stat_t     stat,
  output logic      in_stall,
  output logic      out_valid,
  output cmd_t      cmd
);
  state_t state, state_next;
  logic   out_valid_next;
  logic   in_xfer;
  logic   out_free;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_type)
            REQ_A_PTR:   state_next = ST_IDLE;
            REQ_A_ENTRY: state_next = ST_IDLE;
            REQ_B_ENTRY: state_next = ST_PTR0;
            REQ_B_END:   state_next = ST_SCAN;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_PTR0:      state_next = stat.b_valid ? ST_PTR1 : ST_IDLE;
      ST_PTR1:      state_next = ST_PTR2;
      ST_PTR2:      state_next = ST_WALK_RD;
      ST_WALK_RD:   state_next = stat.walk_done ? ST_IDLE : ST_WALK_WAIT;
      ST_WALK_WAIT: state_next = ST_WALK_MUL;
      ST_WALK_MUL:  state_next = stat.row_ok ? ST_WALK_ACC : ST_WALK_RD;
      ST_WALK_ACC:  state_next = ST_WALK_RD;
      ST_SCAN:      state_next = stat.any_touched ? ST_SCAN_ACC : ST_EMPTY;
      ST_SCAN_ACC:  state_next = stat.keep ? ST_SCAN_EMIT : ST_SCAN;
      ST_SCAN_EMIT: begin
        if (!stat.pend_valid || out_free) state_next = ST_SCAN;
      end
      ST_EMPTY: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_xfer;
        cmd.write_ptr   = in_xfer && in_type == REQ_A_PTR;
        cmd.write_entry = in_xfer && in_type == REQ_A_ENTRY;
      end
      ST_PTR1:      cmd.rd_end    = 1'b1;
      ST_PTR2:      cmd.load_end  = 1'b1;
      ST_WALK_WAIT: cmd.rd_entry  = 1'b1;
      ST_WALK_MUL:  cmd.mul       = stat.row_ok;
      ST_WALK_ACC:  cmd.acc       = 1'b1;
      ST_SCAN:      cmd.scan_pick = stat.any_touched;
      ST_SCAN_ACC:  cmd.scan_check = 1'b1;
      ST_SCAN_EMIT: begin
        if (!stat.pend_valid || out_free) begin
          cmd.hold_row = 1'b1;
          cmd.emit_row = stat.pend_valid;
          if (stat.pend_valid) out_valid_next = 1'b1;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          cmd.emit_last  = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end
endmodule

### hw/rtl/smm_datapath.sv
`timescale 1ns / 1ps
module smm_datapath
  import smm_pkg::*;
#(
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int MAX_INNER = MAX_INNER_DEF,
  parameter int A_ENTRIES = A_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  logic      cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t      cmd,
  output stat_t     stat,
  output out_item_t out_data
);
  localparam int PTR_AW = $clog2(MAX_INNER + 1);
  localparam int ENT_AW = (A_ENTRIES > 1) ? $clog2(A_ENTRIES) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic signed [63:0] S_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S_MIN = {1'b1, {63{1'b0}}};

  // config registers
  logic [6:0]  a_rows, a_cols;
  logic [62:0] drop_threshold;
  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows         <= 7'd64;
      a_cols         <= 7'd64;
      drop_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_A_ROWS:    a_rows <= cfg_data[6:0];
        CFG_A_COLS:    a_cols <= cfg_data[6:0];
        CFG_THRESHOLD: drop_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured item
  in_item_t item;
  always_ff @(posedge clk) begin
    if (cmd.capture) item <= in_data;
  end

  // column start table
  logic [PTR_AW-1:0] ptr_raddr;
  logic [10:0]       ptr_rdata;
  logic              ptr_we;
  assign ptr_we = cmd.write_ptr && (32'(in_data.a_col) <= MAX_INNER);
  assign ptr_raddr = cmd.rd_end ? PTR_AW'(32'(item.b_row) + 1) : PTR_AW'(item.b_row);
  smm_ram #(.WIDTH(11), .DEPTH(MAX_INNER + 1)) u_ptr_ram (
    .clk, .we(ptr_we), .waddr(PTR_AW'(in_data.a_col)), .wdata(in_data.a_ptr),
    .raddr(ptr_raddr), .rdata(ptr_rdata)
  );

  // entry store, read address held until the walk advances
  logic [16:0]       walk_pos, walk_end;
  logic [5:0]        ent_row;
  logic [31:0]       ent_val;
  logic              ent_we;
  assign ent_we = cmd.write_entry && (32'(in_data.a_pos) < A_ENTRIES);
  smm_ram #(.WIDTH(38), .DEPTH(A_ENTRIES)) u_ent_ram (
    .clk, .we(ent_we), .waddr(ENT_AW'(in_data.a_pos)),
    .wdata({in_data.a_row, in_data.a_value}),
    .raddr(ENT_AW'(walk_pos)), .rdata({ent_row, ent_val})
  );

  assign stat.b_valid = (7'(item.b_row) < a_cols) && (32'(item.b_row) < MAX_INNER);

  // walk bounds
  logic [16:0] end_clip;
  assign end_clip = (32'(ptr_rdata) > A_ENTRIES) ? 17'(A_ENTRIES) : 17'(ptr_rdata);
  always_ff @(posedge clk) begin
    if (cmd.rd_end) walk_pos <= 17'(ptr_rdata);
    else if (cmd.rd_entry) walk_pos <= walk_pos + 17'd1;
    if (cmd.load_end) walk_end <= end_clip;
  end
  assign stat.walk_done = walk_pos >= walk_end;

  logic [6:0] rows_eff;
  assign rows_eff = (32'(a_rows) > MAX_ROWS) ? 7'(MAX_ROWS) : a_rows;
  assign stat.row_ok = 7'(ent_row) < rows_eff;

  // product
  logic signed [63:0] prod;
  logic [ROW_W-1:0]   prod_row;
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod     <= 64'(signed'(ent_val)) * 64'(item.b_value);
      prod_row <= ROW_W'(ent_row);
    end
  end

  // lowest touched row
  logic [MAX_ROWS-1:0] touched;
  logic [ROW_W-1:0]    pick;
  always_comb begin
    pick = '0;
    for (int i = MAX_ROWS - 1; i >= 0; i--) begin
      if (touched[i]) pick = ROW_W'(i);
    end
  end
  assign stat.any_touched = |touched;

  // row accumulators, untouched rows read as zero
  logic [ROW_W-1:0]   acc_raddr;
  logic signed [63:0] acc_rdata;
  logic signed [63:0] acc_cur, acc_sum, acc_sat;
  assign acc_raddr = cmd.scan_pick ? pick : ROW_W'(ent_row);
  smm_ram #(.WIDTH(64), .DEPTH(MAX_ROWS)) u_acc_ram (
    .clk, .we(cmd.acc), .waddr(prod_row), .wdata(acc_sat),
    .raddr(acc_raddr), .rdata(acc_rdata)
  );
  assign acc_cur = touched[prod_row] ? acc_rdata : '0;
  assign acc_sum = acc_cur + prod;

  always_comb begin
    acc_sat = acc_sum;
    if (!acc_cur[63] && !prod[63] && acc_sum[63]) acc_sat = S_MAX;
    if (acc_cur[63] && prod[63] && !acc_sum[63])  acc_sat = S_MIN;
  end

  // scan check on the accumulator just read
  logic [ROW_W-1:0]   scan_row;
  logic signed [63:0] scan_val;
  logic [63:0]        scan_mag;
  always_ff @(posedge clk) begin
    if (cmd.scan_pick) scan_row <= pick;
    if (cmd.scan_check) scan_val <= acc_rdata;
  end
  assign scan_mag  = acc_rdata[63] ? (64'd0 - 64'(acc_rdata)) : 64'(acc_rdata);
  assign stat.keep = scan_mag > {1'b0, drop_threshold};

  // parked kept row
  logic [ROW_W-1:0]   pend_row;
  logic signed [63:0] pend_val;
  logic               pend_valid;
  always_ff @(posedge clk) begin
    if (cmd.hold_row) begin
      pend_row <= scan_row;
      pend_val <= scan_val;
    end
  end
  assign stat.pend_valid = pend_valid;

  // touched mask, parked flag
  always_ff @(posedge clk) begin
    if (rst) begin
      touched    <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.acc) touched[prod_row] <= 1'b1;
      if (cmd.scan_check) touched[scan_row] <= 1'b0;
      if (cmd.hold_row) pend_valid <= 1'b1;
      else if (cmd.emit_last) pend_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit_row) begin
      out_data.out_row   <= 6'(pend_row);
      out_data.out_value <= pend_val;
      out_data.col_last  <= 1'b0;
      out_data.col_empty <= 1'b0;
    end else if (cmd.emit_last) begin
      if (pend_valid) begin
        out_data.out_row   <= 6'(pend_row);
        out_data.out_value <= pend_val;
        out_data.col_last  <= 1'b1;
        out_data.col_empty <= 1'b0;
      end else begin
        out_data <= '{out_row: '0, out_value: '0, col_last: 1'b1, col_empty: 1'b1};
      end
    end
  end
endmodule

### hw/rtl/sparse_ccs_matrix_multiply_top.sv
`timescale 1ns / 1ps
// channel | valid     | stall      | payload
// in      | in_valid  | in_stall   | in_data (in_item_t)
// out     | out_valid | out_stall  | out_data (out_item_t)
// cfg     | cfg_we    | -          | cfg_index, cfg_data
// a pointer or entry write does not stall input.
// a b entry stalls input while its column start and end are read and each a entry is walked
// (read, wait, multiply, add); a b entry out of range stalls input only for the range check.
// a column end scans each touched row (pick, check, park if kept); a kept row leaves once the
// next kept row or the column end is found, and shows through the result register.
// rst is synchronous; it clears control, touched rows and the parked flag and resets config.
// out_stall holds the result register and pauses the scan; input waits until the item is done.
module sparse_ccs_matrix_multiply_top
  import smm_pkg::*;
#(
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int MAX_INNER = MAX_INNER_DEF,
  parameter int A_ENTRIES = A_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  cmd_t  cmd;
  stat_t stat;

  smm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_type(req_type_t'(in_data.req_type)), .out_stall,
    .stat, .in_stall, .out_valid, .cmd
  );

  smm_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_INNER(MAX_INNER), .A_ENTRIES(A_ENTRIES)) u_dp (
    .clk, .rst, .in_data, .cfg_we, .cfg_index, .cfg_data, .cmd, .stat, .out_data
  );
endmodule

### hw/rtl/smm_checker.sv
`timescale 1ns / 1ps
module smm_checker
  import smm_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input out_item_t out_data,
  input logic      out_valid,
  input logic      out_stall
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.col_empty |-> out_data.col_last)
    else $error("empty marker without last");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.col_empty |-> out_data.out_value == 64'd0 && out_data.out_row == 6'd0)
    else $error("empty marker carries data");

  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !in_stall |-> out_data.col_last)
    else $error("input taken while column still emitting");
endmodule

bind sparse_ccs_matrix_multiply_top smm_checker u_smm_checker (
  .clk, .rst, .in_stall, .out_data, .out_valid, .out_stall
);
